// ===== src/rhcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhcc_pkg
// Shared types and constants for the RGB to HSV color classifier.
// ----------------------------------------------------------------------------
package rhcc_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // register file
    localparam int          ADDR_BITS     = 4;
    localparam int          CFG_DATA_BITS = 32;
    localparam int unsigned FS_RESET      = 65535;

    typedef enum logic [1:0] {
        REG_LOW_THR  = 2'd0,
        REG_RED_FS   = 2'd1,
        REG_GREEN_FS = 2'd2,
        REG_BLUE_FS  = 2'd3
    } t_reg_idx;

    // which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // hue sector offsets and scale
    localparam int HUE_SCALE = 60;
    localparam int HUE_GREEN = 120;
    localparam int HUE_BLUE  = 240;
    localparam int HUE_FULL  = 360;
    localparam int PCT_SCALE = 100;

    // quotient bits of the hue / saturation dividers (quotients < 128)
    localparam int DQ_BITS = 7;

    // classification
    localparam int          NUM_CLASSES = 8;
    localparam logic [3:0]  CLASS_NONE  = 4'd8;
    localparam int          HUE_TOL     = 30;
    localparam int          SV_TOL      = 100;

    localparam int CLS_HUE [NUM_CLASSES] = '{0, 0, 0, 120, 240, 60, 180, 300};
    localparam int CLS_SAT [NUM_CLASSES] = '{0, 0, 100, 100, 100, 100, 100, 100};
    localparam int CLS_VAL [NUM_CLASSES] = '{0, 100, 100, 100, 100, 100, 100, 100};

endpackage

// ===== src/rgb_to_hsv_color_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_color_classifier_core
// Thresholds, clips and normalizes raw RGB counts, converts to HSV and
// classifies the color against a fixed eight-entry table.
// ----------------------------------------------------------------------------
// Fully pipelined: one RGB beat may be started every clock (busy is tied
// low), and each beat produces exactly one result, strobed on o_valid for a
// single cycle; the receiver cannot stall it. The pipeline has FRAC_BITS + 12
// register stages: one clip stage, FRAC_BITS+1 restoring-division stages
// for the three ratios, one max/min stage, seven shared-depth division
// stages for hue and saturation, one HSV stage and one classification
// stage. Configuration (threshold and full-scale registers, APB at byte
// addresses 0/4/8/12) must only change while no beat is in flight; the
// pipeline reads it live.
// ----------------------------------------------------------------------------
module rgb_to_hsv_color_classifier_core #(
    parameter int COUNT_BITS = rhcc_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = rhcc_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command channel
    input  logic                               start,
    output logic                               busy,
    input  logic [COUNT_BITS-1:0]              i_red_count,
    input  logic [COUNT_BITS-1:0]              i_green_count,
    input  logic [COUNT_BITS-1:0]              i_blue_count,
    // result channel
    output logic                               o_valid,
    output logic [8:0]                         o_hue_degrees,
    output logic [6:0]                         o_saturation_pct,
    output logic [6:0]                         o_value_pct,
    output logic [3:0]                         o_color_class,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rhcc_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [rhcc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [rhcc_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    localparam int CB = COUNT_BITS;
    localparam int FB = FRAC_BITS;
    localparam int RW = FB + 1;           // ratio width, ratio <= 2^FB
    localparam int NB = RW + 6;           // 60*|diff|
    localparam int SB = RW + 7;           // 100*delta
    localparam int DQ = rhcc_pkg::DQ_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CB-1:0] r_low_thr;
    logic [CB-1:0] r_fs [3];
    rhcc_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_idx  = rhcc_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr <= '0;
            r_fs[0]   <= CB'(rhcc_pkg::FS_RESET);
            r_fs[1]   <= CB'(rhcc_pkg::FS_RESET);
            r_fs[2]   <= CB'(rhcc_pkg::FS_RESET);
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                rhcc_pkg::REG_LOW_THR:  r_low_thr <= pwdata[CB-1:0];
                rhcc_pkg::REG_RED_FS:   r_fs[0]   <= pwdata[CB-1:0];
                rhcc_pkg::REG_GREEN_FS: r_fs[1]   <= pwdata[CB-1:0];
                rhcc_pkg::REG_BLUE_FS:  r_fs[2]   <= pwdata[CB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            rhcc_pkg::REG_LOW_THR:  prdata = rhcc_pkg::CFG_DATA_BITS'(r_low_thr);
            rhcc_pkg::REG_RED_FS:   prdata = rhcc_pkg::CFG_DATA_BITS'(r_fs[0]);
            rhcc_pkg::REG_GREEN_FS: prdata = rhcc_pkg::CFG_DATA_BITS'(r_fs[1]);
            rhcc_pkg::REG_BLUE_FS:  prdata = rhcc_pkg::CFG_DATA_BITS'(r_fs[2]);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage C: threshold then clip to full scale
    // ------------------------------------------------------------------
    logic [CB-1:0] w_raw [3];
    logic [CB-1:0] n_cnt [3];
    logic [CB-1:0] r_cnt [3];
    logic          r_cnt_vld;

    assign w_raw[0] = i_red_count;
    assign w_raw[1] = i_green_count;
    assign w_raw[2] = i_blue_count;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_cnt[ch] = (w_raw[ch] < r_low_thr) ? '0 : w_raw[ch];
            if (n_cnt[ch] > r_fs[ch]) n_cnt[ch] = r_fs[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt_vld <= 1'b0;
        else          r_cnt_vld <= start && !busy;
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) r_cnt[ch] <= n_cnt[ch];
    end

    // ------------------------------------------------------------------
    // Ratio division: (cnt << FB) / fs, one quotient bit per stage.
    // Since cnt <= fs the first stage yields the integer bit; the rest
    // shift in zeros. The remainder stays below fs whenever fs is nonzero.
    // ------------------------------------------------------------------
    logic [CB-1:0] r_dv_rem [FB+1][3];
    logic [RW-1:0] r_dv_q   [FB+1][3];
    logic          r_dv_vld [FB+1];

    for (genvar k = 0; k <= FB; k++) begin : g_rdiv
        logic [CB-1:0] n_rem [3];
        logic [RW-1:0] n_q   [3];
        logic          w_vin;

        always_comb begin
            logic [CB:0] t;
            logic        ge;
            for (int ch = 0; ch < 3; ch++) begin
                if (k == 0) t = {1'b0, r_cnt[ch]};
                else        t = {r_dv_rem[(k == 0) ? 0 : k-1][ch], 1'b0};
                ge = (t >= {1'b0, r_fs[ch]});
                n_rem[ch] = ge ? CB'(t - {1'b0, r_fs[ch]}) : CB'(t);
                if (k == 0) n_q[ch] = RW'(ge);
                else        n_q[ch] = {r_dv_q[(k == 0) ? 0 : k-1][ch][RW-2:0], ge};
            end
            w_vin = (k == 0) ? r_cnt_vld : r_dv_vld[(k == 0) ? 0 : k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_vld[k] <= 1'b0;
            else          r_dv_vld[k] <= w_vin;
        end

        always_ff @(posedge i_clk) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_dv_rem[k][ch] <= n_rem[ch];
                r_dv_q[k][ch]   <= n_q[ch];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage M: max/min, delta, hue and saturation numerators, value percent
    // ------------------------------------------------------------------
    logic [RW-1:0]     w_rat [3];
    logic [RW-1:0]     n_m_mx, n_m_dl;
    logic [NB-1:0]     n_m_num;
    logic [SB-1:0]     n_m_sn;
    logic              n_m_neg;
    rhcc_pkg::t_sector n_m_sec;
    logic [6:0]        n_m_val;

    logic [RW-1:0]     r_m_mx, r_m_dl;
    logic [NB-1:0]     r_m_num;
    logic [SB-1:0]     r_m_sn;
    logic              r_m_neg;
    rhcc_pkg::t_sector r_m_sec;
    logic [6:0]        r_m_val;
    logic              r_m_vld;

    always_comb begin
        logic [RW-1:0] mn;
        logic [RW:0]   diff;
        logic [RW-1:0] absd;
        logic [RW+6:0] vprod;
        // a zero full scale reads as a zero ratio
        for (int ch = 0; ch < 3; ch++)
            w_rat[ch] = (r_fs[ch] == '0) ? '0 : r_dv_q[FB][ch];
        n_m_mx = w_rat[0];
        mn     = w_rat[0];
        if (w_rat[1] > n_m_mx) n_m_mx = w_rat[1];
        if (w_rat[2] > n_m_mx) n_m_mx = w_rat[2];
        if (w_rat[1] < mn)     mn     = w_rat[1];
        if (w_rat[2] < mn)     mn     = w_rat[2];
        n_m_dl = n_m_mx - mn;
        // ties resolve red, then green, then blue
        if (n_m_mx == w_rat[0]) begin
            n_m_sec = rhcc_pkg::SEC_RED;
            diff    = {1'b0, w_rat[1]} - {1'b0, w_rat[2]};
        end else if (n_m_mx == w_rat[1]) begin
            n_m_sec = rhcc_pkg::SEC_GREEN;
            diff    = {1'b0, w_rat[2]} - {1'b0, w_rat[0]};
        end else begin
            n_m_sec = rhcc_pkg::SEC_BLUE;
            diff    = {1'b0, w_rat[0]} - {1'b0, w_rat[1]};
        end
        n_m_neg = diff[RW];
        absd    = n_m_neg ? RW'(-diff) : diff[RW-1:0];
        n_m_num = NB'(absd) * NB'(rhcc_pkg::HUE_SCALE);
        n_m_sn  = SB'(n_m_dl) * SB'(rhcc_pkg::PCT_SCALE);
        vprod   = (RW+7)'(n_m_mx) * (RW+7)'(rhcc_pkg::PCT_SCALE);
        n_m_val = 7'(vprod >> FB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_vld <= 1'b0;
        else          r_m_vld <= r_dv_vld[FB];
    end

    always_ff @(posedge i_clk) begin
        r_m_mx  <= n_m_mx;
        r_m_dl  <= n_m_dl;
        r_m_num <= n_m_num;
        r_m_sn  <= n_m_sn;
        r_m_neg <= n_m_neg;
        r_m_sec <= n_m_sec;
        r_m_val <= n_m_val;
    end

    // ------------------------------------------------------------------
    // Hue and saturation division, side by side. Both quotients are
    // below 128, so the top bits of each numerator seed the remainder
    // and each stage shifts in one more numerator bit.
    // ------------------------------------------------------------------
    logic [RW-1:0]     r_q_hrem [DQ];
    logic [DQ-1:0]     r_q_hq   [DQ];
    logic [RW-1:0]     r_q_srem [DQ];
    logic [DQ-1:0]     r_q_sq   [DQ];
    logic [RW-1:0]     r_q_mx   [DQ];
    logic [RW-1:0]     r_q_dl   [DQ];
    logic [NB-1:0]     r_q_num  [DQ];
    logic [SB-1:0]     r_q_sn   [DQ];
    logic              r_q_neg  [DQ];
    rhcc_pkg::t_sector r_q_sec  [DQ];
    logic [6:0]        r_q_val  [DQ];
    logic              r_q_vld  [DQ];

    for (genvar j = 0; j < DQ; j++) begin : g_qdiv
        logic [RW-1:0]     w_hrem, w_srem, w_mx, w_dl;
        logic [DQ-1:0]     w_hq, w_sq;
        logic [NB-1:0]     w_num;
        logic [SB-1:0]     w_sn;
        logic              w_neg, w_vin;
        rhcc_pkg::t_sector w_sec;
        logic [6:0]        w_val;
        logic [RW-1:0]     n_hrem, n_srem;
        logic [DQ-1:0]     n_hq, n_sq;

        if (j == 0) begin : g_first
            assign w_hrem = RW'(r_m_num[NB-1:DQ]);
            assign w_srem = r_m_sn[SB-1:DQ];
            assign w_hq   = '0;
            assign w_sq   = '0;
            assign w_mx   = r_m_mx;
            assign w_dl   = r_m_dl;
            assign w_num  = r_m_num;
            assign w_sn   = r_m_sn;
            assign w_neg  = r_m_neg;
            assign w_sec  = r_m_sec;
            assign w_val  = r_m_val;
            assign w_vin  = r_m_vld;
        end else begin : g_next
            assign w_hrem = r_q_hrem[j-1];
            assign w_srem = r_q_srem[j-1];
            assign w_hq   = r_q_hq[j-1];
            assign w_sq   = r_q_sq[j-1];
            assign w_mx   = r_q_mx[j-1];
            assign w_dl   = r_q_dl[j-1];
            assign w_num  = r_q_num[j-1];
            assign w_sn   = r_q_sn[j-1];
            assign w_neg  = r_q_neg[j-1];
            assign w_sec  = r_q_sec[j-1];
            assign w_val  = r_q_val[j-1];
            assign w_vin  = r_q_vld[j-1];
        end

        always_comb begin
            logic [RW:0] th, ts;
            logic        geh, ges;
            th   = {w_hrem, w_num[DQ-1-j]};
            ts   = {w_srem, w_sn[DQ-1-j]};
            geh  = (th >= {1'b0, w_dl});
            ges  = (ts >= {1'b0, w_mx});
            n_hrem = geh ? RW'(th - {1'b0, w_dl}) : RW'(th);
            n_srem = ges ? RW'(ts - {1'b0, w_mx}) : RW'(ts);
            n_hq   = {w_hq[DQ-2:0], geh};
            n_sq   = {w_sq[DQ-2:0], ges};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_q_vld[j] <= 1'b0;
            else          r_q_vld[j] <= w_vin;
        end

        always_ff @(posedge i_clk) begin
            r_q_hrem[j] <= n_hrem;
            r_q_srem[j] <= n_srem;
            r_q_hq[j]   <= n_hq;
            r_q_sq[j]   <= n_sq;
            r_q_mx[j]   <= w_mx;
            r_q_dl[j]   <= w_dl;
            r_q_num[j]  <= w_num;
            r_q_sn[j]   <= w_sn;
            r_q_neg[j]  <= w_neg;
            r_q_sec[j]  <= w_sec;
            r_q_val[j]  <= w_val;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: hue by sector (red truncates toward zero, green and blue
    // floor, so a negative offset with a remainder rounds down), sat.
    // ------------------------------------------------------------------
    logic [8:0] n_h_hue, r_h_hue;
    logic [6:0] n_h_sat, r_h_sat;
    logic [6:0] r_h_val;
    logic       r_h_vld;

    always_comb begin
        logic [8:0] q;
        logic [8:0] base;
        logic       rnz;
        q    = 9'(r_q_hq[DQ-1]);
        rnz  = (r_q_hrem[DQ-1] != '0);
        base = '0;
        case (r_q_sec[DQ-1])
            rhcc_pkg::SEC_RED:   base = '0;
            rhcc_pkg::SEC_GREEN: base = 9'(rhcc_pkg::HUE_GREEN);
            rhcc_pkg::SEC_BLUE:  base = 9'(rhcc_pkg::HUE_BLUE);
            default:             base = '0;
        endcase
        if (r_q_dl[DQ-1] == '0) begin
            n_h_hue = '0;
        end else if (r_q_sec[DQ-1] == rhcc_pkg::SEC_RED) begin
            n_h_hue = (r_q_neg[DQ-1] && q != '0) ? 9'(rhcc_pkg::HUE_FULL) - q : q;
        end else if (r_q_neg[DQ-1]) begin
            n_h_hue = base - q - 9'(rnz);
        end else begin
            n_h_hue = base + q;
        end
        n_h_sat = (r_q_mx[DQ-1] == '0) ? '0 : r_q_sq[DQ-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h_vld <= 1'b0;
        else          r_h_vld <= r_q_vld[DQ-1];
    end

    always_ff @(posedge i_clk) begin
        r_h_hue <= n_h_hue;
        r_h_sat <= n_h_sat;
        r_h_val <= r_q_val[DQ-1];
    end

    // ------------------------------------------------------------------
    // Stage O: classification, first matching table entry wins
    // ------------------------------------------------------------------
    logic [3:0] n_cls;
    logic [8:0] r_o_hue;
    logic [6:0] r_o_sat, r_o_val;
    logic [3:0] r_o_cls;
    logic       r_o_vld;

    always_comb begin
        int dh, ds, dv;
        n_cls = rhcc_pkg::CLASS_NONE;
        for (int i = rhcc_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
            dh = rhcc_pkg::CLS_HUE[i] - int'(r_h_hue);
            ds = rhcc_pkg::CLS_SAT[i] - int'(r_h_sat);
            dv = rhcc_pkg::CLS_VAL[i] - int'(r_h_val);
            if (dh < 0) dh = -dh;
            if (ds < 0) ds = -ds;
            if (dv < 0) dv = -dv;
            if (dh < rhcc_pkg::HUE_TOL && ds < rhcc_pkg::SV_TOL && dv < rhcc_pkg::SV_TOL)
                n_cls = 4'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else          r_o_vld <= r_h_vld;
    end

    always_ff @(posedge i_clk) begin
        r_o_hue <= r_h_hue;
        r_o_sat <= r_h_sat;
        r_o_val <= r_h_val;
        r_o_cls <= n_cls;
    end

    assign o_valid          = r_o_vld;
    assign o_hue_degrees    = r_o_hue;
    assign o_saturation_pct = r_o_sat;
    assign o_value_pct      = r_o_val;
    assign o_color_class    = r_o_cls;

endmodule

// ===== bench/rgb_to_hsv_color_classifier_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_color_classifier_core_test
// Self-checking bench for the RGB to HSV classifier core. Beats go in
// through the start/busy channel in random bursts. Each beat's HSV triple
// and class are predicted from a local copy of the threshold and
// full-scale registers. Every strobed result is checked in order against
// the oldest prediction. The registers are rewritten over APB between
// phases, only once the pipeline has drained.
// ----------------------------------------------------------------------------
module rgb_to_hsv_color_classifier_core_test;

    localparam int CBITS    = 16;
    localparam int FBITS    = 16;
    localparam int LATENCY  = FBITS + 12;
    localparam int MAX_CYC  = 400000;

    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] val;
        logic [3:0] cls;
    } t_hsv_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [CBITS-1:0]  i_red_count;
    logic [CBITS-1:0]  i_green_count;
    logic [CBITS-1:0]  i_blue_count;
    logic              o_valid;
    logic [8:0]        o_hue_degrees;
    logic [6:0]        o_saturation_pct;
    logic [6:0]        o_value_pct;
    logic [3:0]        o_color_class;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [rhcc_pkg::ADDR_BITS-1:0]     paddr;
    logic [rhcc_pkg::CFG_DATA_BITS-1:0] pwdata;
    logic [rhcc_pkg::CFG_DATA_BITS-1:0] prdata;
    logic              pready;

    rgb_to_hsv_color_classifier_core #(
        .COUNT_BITS(CBITS),
        .FRAC_BITS (FBITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_red_count     (i_red_count),
        .i_green_count   (i_green_count),
        .i_blue_count    (i_blue_count),
        .o_valid         (o_valid),
        .o_hue_degrees   (o_hue_degrees),
        .o_saturation_pct(o_saturation_pct),
        .o_value_pct     (o_value_pct),
        .o_color_class   (o_color_class),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // local shadow of the register file
    logic [15:0] shadow_thr;
    logic [15:0] shadow_fs [3];

    t_hsv_result pending_hsv [$];
    int          mismatches;
    int          beats_sent;
    int          results_seen;
    int          phases_run;
    int          cycle_count;
    int          burst_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop if the pipeline hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYC) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_hsv.size());
            $display("rgb_to_hsv_color_classifier_core test failed");
            $finish;
        end
    end

    // threshold, clip, normalize to Q.FBITS
    function automatic longint norm_ratio(logic [15:0] raw, logic [15:0] fs);
        longint c;
        c = raw;
        if (c < shadow_thr) c = 0;
        if (c > fs) c = fs;
        if (fs == 0) return 0;
        return (c << FBITS) / fs;
    endfunction

    function automatic int abs_diff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_hsv_result classify_rgb(logic [15:0] rc, logic [15:0] gc,
                                                 logic [15:0] bc);
        t_hsv_result res;
        longint r, g, b, mx, mn, delta, q;
        int hue, sat, val, cls;
        r = norm_ratio(rc, shadow_fs[0]);
        g = norm_ratio(gc, shadow_fs[1]);
        b = norm_ratio(bc, shadow_fs[2]);
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        // ties resolve red, then green, then blue
        if (delta == 0) begin
            hue = 0;
        end else if (mx == r) begin
            q = (rhcc_pkg::HUE_SCALE * (g - b)) / delta;   // truncates toward zero
            if (q < 0) q += rhcc_pkg::HUE_FULL;
            hue = int'(q);
        end else if (mx == g) begin
            hue = int'((rhcc_pkg::HUE_GREEN * delta + rhcc_pkg::HUE_SCALE * (b - r))
                       / delta);
        end else begin
            hue = int'((rhcc_pkg::HUE_BLUE * delta + rhcc_pkg::HUE_SCALE * (r - g))
                       / delta);
        end
        sat = (mx == 0) ? 0 : int'((rhcc_pkg::PCT_SCALE * delta) / mx);
        val = int'((rhcc_pkg::PCT_SCALE * mx) >>> FBITS);
        // first match wins; no hue wrap near 360
        cls = rhcc_pkg::NUM_CLASSES;
        for (int i = rhcc_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
            if (abs_diff(rhcc_pkg::CLS_HUE[i], hue) < rhcc_pkg::HUE_TOL &&
                abs_diff(rhcc_pkg::CLS_SAT[i], sat) < rhcc_pkg::SV_TOL &&
                abs_diff(rhcc_pkg::CLS_VAL[i], val) < rhcc_pkg::SV_TOL) cls = i;
        end
        res.hue = hue[8:0];
        res.sat = sat[6:0];
        res.val = val[6:0];
        res.cls = cls[3:0];
        return res;
    endfunction

    // result checker: outputs sampled at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        t_hsv_result want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_hsv.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result hue=%0d sat=%0d val=%0d cls=%0d",
                             o_hue_degrees, o_saturation_pct, o_value_pct,
                             o_color_class);
            end else begin
                want = pending_hsv.pop_front();
                if (want.hue !== o_hue_degrees || want.sat !== o_saturation_pct ||
                    want.val !== o_value_pct || want.cls !== o_color_class) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp h/s/v/c=%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.hue, want.sat, want.val, want.cls,
                                 o_hue_degrees, o_saturation_pct, o_value_pct,
                                 o_color_class);
                end
            end
        end
    end

    // one beat; caller is at a rising edge, returns at the accept edge
    task automatic send_rgb(logic [15:0] rc, logic [15:0] gc, logic [15:0] bc);
        start         <= 1'b1;
        i_red_count   <= rc;
        i_green_count <= gc;
        i_blue_count  <= bc;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_hsv.push_back(classify_rgb(rc, gc, bc));
        beats_sent++;
    endtask

    // burst/gap pacing around send_rgb
    task automatic send_paced(logic [15:0] rc, logic [15:0] gc, logic [15:0] bc);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            // now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 16);
        end
        burst_left--;
        send_rgb(rc, gc, bc);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_hsv.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(rhcc_pkg::t_reg_idx idx, logic [15:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, data};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == rhcc_pkg::REG_LOW_THR) shadow_thr = data;
        else shadow_fs[int'(idx) - 1] = data;
    endtask

    task automatic set_config(logic [15:0] thr, logic [15:0] rfs, logic [15:0] gfs,
                              logic [15:0] bfs);
        drain();
        apb_write(rhcc_pkg::REG_LOW_THR, thr);
        apb_write(rhcc_pkg::REG_RED_FS, rfs);
        apb_write(rhcc_pkg::REG_GREEN_FS, gfs);
        apb_write(rhcc_pkg::REG_BLUE_FS, bfs);
        @(posedge i_clk);
        phases_run++;
    endtask

    // pick a count: fully random, near a full scale, small, near the threshold, or extreme
    function automatic logic [15:0] pick_count(int ch);
        case ($urandom_range(0, 5))
            0, 1:    return 16'($urandom);
            2:       return shadow_fs[ch] - 16'($urandom_range(0, 40));
            3:       return 16'($urandom_range(0, 300));
            4:       return shadow_thr + 16'($urandom_range(0, 3)) - 16'd1;
            default: return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
        endcase
    endfunction

    task automatic test_directed;
        // reset registers first
        send_rgb(16'h0000, 16'h0000, 16'h0000);   // black
        send_rgb(16'hffff, 16'hffff, 16'hffff);   // white
        send_rgb(16'hffff, 16'h0000, 16'h0000);   // red
        send_rgb(16'h0000, 16'hffff, 16'h0000);   // lime
        send_rgb(16'h0000, 16'h0000, 16'hffff);   // blue
        send_rgb(16'hffff, 16'hffff, 16'h0000);   // yellow
        send_rgb(16'h0000, 16'hffff, 16'hffff);   // cyan
        send_rgb(16'hffff, 16'h0000, 16'hffff);   // magenta
        send_rgb(16'hffff, 16'h0000, 16'h1c00);   // hue just below 360, no wrap
        send_rgb(16'hffff, 16'h1c00, 16'h0000);   // hue just above 0
        send_rgb(16'h8000, 16'h4000, 16'h2000);   // orange; matches the first table entry
        send_rgb(16'h0001, 16'h0000, 16'h0000);   // tiny delta
        // threshold above the full scale: a passing count still clips
        set_config(16'd50000, 16'd30000, 16'd1, 16'hffff);
        send_rgb(16'd60000, 16'd49999, 16'd50000);
        send_rgb(16'd49999, 16'd60000, 16'hffff);
        send_rgb(16'hffff, 16'hffff, 16'd50001);
        set_config(16'hffff, 16'd1, 16'd1, 16'd1);
        send_rgb(16'hffff, 16'hfffe, 16'hffff);
        send_rgb(16'hfffe, 16'hffff, 16'hfffe);
    endtask

    task automatic test_random_phase(logic [15:0] thr, logic [15:0] rfs,
                                     logic [15:0] gfs, logic [15:0] bfs, int n);
        set_config(thr, rfs, gfs, bfs);
        burst_left = 0;
        for (int k = 0; k < n; k++)
            send_paced(pick_count(0), pick_count(1), pick_count(2));
    endtask

    // sender holds off until every prediction has been matched
    task automatic test_drain_pause;
        for (int k = 0; k < 40; k++) begin
            send_paced(16'($urandom), 16'($urandom), 16'($urandom));
            if (k == 20) drain();
        end
    endtask

    initial begin
        cycle_count   = 0;
        mismatches    = 0;
        beats_sent    = 0;
        results_seen  = 0;
        phases_run    = 0;
        burst_left    = 0;
        shadow_thr    = 16'd0;
        shadow_fs[0]  = 16'(rhcc_pkg::FS_RESET);
        shadow_fs[1]  = 16'(rhcc_pkg::FS_RESET);
        shadow_fs[2]  = 16'(rhcc_pkg::FS_RESET);
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_red_count   = '0;
        i_green_count = '0;
        i_blue_count  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(16'd0, 16'hffff, 16'hffff, 16'hffff, 250);
        test_random_phase(16'd0, 16'd1, 16'd1, 16'd1, 120);
        test_random_phase(16'hffff, 16'hffff, 16'd1, 16'h8000, 80);
        test_random_phase(16'($urandom_range(0, 2000)), 16'($urandom_range(1, 65535)),
                          16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                          250);
        test_random_phase(16'($urandom), 16'($urandom_range(1, 65535)),
                          16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                          250);
        test_random_phase(16'd100, 16'd4096, 16'd255, 16'd65000, 250);
        test_drain_pause();

        drain();
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("covered %0d beats and %0d results over %0d register settings",
                 beats_sent, results_seen, phases_run + 1);
        $display("mismatches: %0d, predictions left over: %0d",
                 mismatches, pending_hsv.size());
        if (mismatches == 0 && pending_hsv.size() == 0) begin
            $display("rgb_to_hsv_color_classifier_core test passed");
        end else begin
            $display("rgb_to_hsv_color_classifier_core test failed");
        end
        $finish;
    end

endmodule

// ===== rgb_to_hsv_color_classifier_core.f =====
src/rhcc_pkg.sv
src/rgb_to_hsv_color_classifier_core.sv
bench/rgb_to_hsv_color_classifier_core_test.sv
